[rtl/uart_fifo_xon_xoff_core_assert.svh]
// Assertion macros shared by the serial buffer core.
`ifndef UART_FIFO_XON_XOFF_CORE_ASSERT_SVH
`define UART_FIFO_XON_XOFF_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define UFX_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ufx assertion failed");

// Next-cycle implication, disabled while reset is high.
`define UFX_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ufx assertion failed");

`endif

[rtl/ufx_pkg.sv]
// Package: types, codes and defaults of the serial buffer core.
`timescale 1ns / 1ps
package ufx_pkg;

   localparam int RX_DEPTH_DEF = 128;
   localparam int TX_DEPTH_DEF = 64;

   localparam int REQ_TYPE_W  = 3;
   localparam int BYTE_W      = 8;
   localparam int PORT_W      = 2;
   localparam int MARK_W      = 7;
   localparam int RX_LEVEL_W  = 7;
   localparam int TX_LEVEL_W  = 6;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 8;
   // wide enough for any level (up to 255) plus one, and for a mark
   localparam int CMP_W       = 9;

   typedef enum logic [REQ_TYPE_W-1:0] {
      REQ_RX_BYTE    = 3'd0,
      REQ_HOST_READ  = 3'd1,
      REQ_HOST_WRITE = 3'd2,
      REQ_TX_READY   = 3'd3,
      REQ_RX_FLUSH   = 3'd4
   } req_code_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_FLOW_ENABLE  = 3'd0,
      CSR_RX_HIGH_MARK = 3'd1,
      CSR_RX_LOW_MARK  = 3'd2,
      CSR_XON_BYTE     = 3'd3,
      CSR_XOFF_BYTE    = 3'd4
   } csr_index_type;

   typedef enum logic [1:0] {
      FLOW_XON_SENT  = 2'd0,
      FLOW_XOFF_PEND = 2'd1,
      FLOW_XOFF_SENT = 2'd2,
      FLOW_XON_PEND  = 2'd3
   } flow_mode_type;

   typedef enum logic [1:0] {
      LINE_NONE = 2'd0,
      LINE_FLOW = 2'd1,
      LINE_BUF  = 2'd2
   } line_src_type;

   localparam logic              FLOW_ENABLE_RST  = 1'b1;
   localparam logic [MARK_W-1:0] RX_HIGH_MARK_RST = 7'd96;
   localparam logic [MARK_W-1:0] RX_LOW_MARK_RST  = 7'd64;
   localparam logic [BYTE_W-1:0] XON_BYTE_RST     = 8'd17;
   localparam logic [BYTE_W-1:0] XOFF_BYTE_RST    = 8'd19;

   // ring pointer commands
   typedef struct packed {
      logic push;
      logic pop;
      logic flush;
   } ring_ctl_type;

   // ring status
   typedef struct packed {
      logic full;
      logic empty;
   } ring_flag_type;

endpackage

[rtl/ufx_ram.sv]
// Generic single-port RAM with registered read.
`timescale 1ns / 1ps
module ufx_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     en,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         if (we) begin
            mem_ff[addr] <= wdata;
         end else begin
            rdata_ff <= mem_ff[addr];
         end
      end
   end

   assign rdata = rdata_ff;

endmodule

[rtl/ufx_ring.sv]
// Ring buffer pointers: head, tail, level, full and empty.
`timescale 1ns / 1ps
module ufx_ring #(
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     reset,
   input  ufx_pkg::ring_ctl_type    ctl,
   output logic [$clog2(DEPTH)-1:0] head,
   output logic [$clog2(DEPTH)-1:0] tail,
   output logic [$clog2(DEPTH)-1:0] level,
   output ufx_pkg::ring_flag_type   flag
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam logic [PTR_W-1:0] LAST    = PTR_W'(DEPTH - 1);
   localparam logic [PTR_W:0]   DEPTH_L = (PTR_W + 1)'(DEPTH);

   logic [PTR_W-1:0] head_ff, head_in;
   logic [PTR_W-1:0] tail_ff, tail_in;
   logic [PTR_W-1:0] head_nxt, tail_nxt;
   logic [PTR_W:0]   diff, diff_wrap;

   assign head_nxt = (head_ff == LAST) ? '0 : head_ff + 1'b1;
   assign tail_nxt = (tail_ff == LAST) ? '0 : tail_ff + 1'b1;

   assign diff      = {1'b0, head_ff} - {1'b0, tail_ff};
   assign diff_wrap = {1'b0, head_ff} + DEPTH_L - {1'b0, tail_ff};

   always_comb begin
      head_in = head_ff;
      tail_in = tail_ff;
      if (ctl.push) begin
         head_in = head_nxt;
      end
      if (ctl.pop) begin
         tail_in = tail_nxt;
      end else if (ctl.flush) begin
         tail_in = head_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         tail_ff <= '0;
      end else begin
         head_ff <= head_in;
         tail_ff <= tail_in;
      end
   end

   assign head       = head_ff;
   assign tail       = tail_ff;
   assign level      = (head_ff >= tail_ff) ? diff[PTR_W-1:0] : diff_wrap[PTR_W-1:0];
   assign flag.full  = (head_nxt == tail_ff);
   assign flag.empty = (head_ff == tail_ff);

endmodule

[rtl/uart_fifo_xon_xoff_core.sv]
// Top level: serial receive/transmit buffers with XON/XOFF flow control.
`timescale 1ns / 1ps
`include "uart_fifo_xon_xoff_core_assert.svh"
// One request is taken in every clock cycle (busy stays low), and its result
// shows on the rsp_ ports for exactly one cycle, the cycle right after the
// request was accepted, marked by rsp_strobe. That delay of the result comes
// from the registered read port of the buffer RAMs: a host read or a
// transmitter-ready request fetches its byte at the accepting edge, and the
// byte appears with the strobe. The receiver cannot stall, so take the result
// in that cycle. Level, enable, port and flow outputs show the state after
// the request. The buffers come out of reset with no clearing pass; an entry
// is only ever read after it was written. Configuration writes take effect
// at the next edge; write them only while no request is in flight.
module uart_fifo_xon_xoff_core #(
   parameter int RX_DEPTH = ufx_pkg::RX_DEPTH_DEF,
   parameter int TX_DEPTH = ufx_pkg::TX_DEPTH_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   // request channel
   input  logic                              start,
   output logic                              busy,
   input  logic [ufx_pkg::REQ_TYPE_W-1:0]    req_type,
   input  logic [ufx_pkg::BYTE_W-1:0]        req_data_byte,
   input  logic [ufx_pkg::PORT_W-1:0]        req_port,
   // result channel
   output logic                              rsp_strobe,
   output logic [ufx_pkg::BYTE_W-1:0]        rsp_read_data,
   output logic                              rsp_read_empty,
   output logic [ufx_pkg::BYTE_W-1:0]        rsp_line_byte,
   output logic                              rsp_line_valid,
   output logic                              rsp_write_refused,
   output logic                              rsp_rx_dropped,
   output logic                              rsp_tx_irq_on,
   output logic [ufx_pkg::PORT_W-1:0]        rsp_tx_port,
   output logic [1:0]                        rsp_flow_state,
   output logic [ufx_pkg::RX_LEVEL_W-1:0]    rsp_rx_level,
   output logic [ufx_pkg::TX_LEVEL_W-1:0]    rsp_tx_level,
   // configuration write port
   input  logic                              csr_we,
   input  logic [ufx_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [ufx_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   localparam int RX_PTR_W = $clog2(RX_DEPTH);
   localparam int TX_PTR_W = $clog2(TX_DEPTH);
   localparam int CMP_W    = ufx_pkg::CMP_W;

   // ---------------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------------
   logic                               flow_enable_ff;
   logic [ufx_pkg::MARK_W-1:0]         rx_high_mark_ff;
   logic [ufx_pkg::MARK_W-1:0]         rx_low_mark_ff;
   logic [ufx_pkg::BYTE_W-1:0]         xon_byte_ff;
   logic [ufx_pkg::BYTE_W-1:0]         xoff_byte_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         flow_enable_ff  <= ufx_pkg::FLOW_ENABLE_RST;
         rx_high_mark_ff <= ufx_pkg::RX_HIGH_MARK_RST;
         rx_low_mark_ff  <= ufx_pkg::RX_LOW_MARK_RST;
         xon_byte_ff     <= ufx_pkg::XON_BYTE_RST;
         xoff_byte_ff    <= ufx_pkg::XOFF_BYTE_RST;
      end else if (csr_we) begin
         unique case (ufx_pkg::csr_index_type'(csr_index))
            ufx_pkg::CSR_FLOW_ENABLE:  flow_enable_ff  <= csr_wdata[0];
            ufx_pkg::CSR_RX_HIGH_MARK: rx_high_mark_ff <= csr_wdata[ufx_pkg::MARK_W-1:0];
            ufx_pkg::CSR_RX_LOW_MARK:  rx_low_mark_ff  <= csr_wdata[ufx_pkg::MARK_W-1:0];
            ufx_pkg::CSR_XON_BYTE:     xon_byte_ff     <= csr_wdata;
            ufx_pkg::CSR_XOFF_BYTE:    xoff_byte_ff    <= csr_wdata;
            default: ;  // unmapped index: write is dropped
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // Ring pointers and buffer RAMs
   // ---------------------------------------------------------------------
   ufx_pkg::ring_ctl_type  rx_ctl, tx_ctl;
   ufx_pkg::ring_flag_type rx_flag, tx_flag;
   logic [RX_PTR_W-1:0]    rx_head, rx_tail, rx_level;
   logic [TX_PTR_W-1:0]    tx_head, tx_tail, tx_level;
   logic [ufx_pkg::BYTE_W-1:0] rx_rdata, tx_rdata;

   ufx_ring #(.DEPTH(RX_DEPTH)) u_rx_ring (
      .clock (clock),
      .reset (reset),
      .ctl   (rx_ctl),
      .head  (rx_head),
      .tail  (rx_tail),
      .level (rx_level),
      .flag  (rx_flag)
   );

   ufx_ring #(.DEPTH(TX_DEPTH)) u_tx_ring (
      .clock (clock),
      .reset (reset),
      .ctl   (tx_ctl),
      .head  (tx_head),
      .tail  (tx_tail),
      .level (tx_level),
      .flag  (tx_flag)
   );

   // single port each: a push writes at head, a pop reads at tail
   ufx_ram #(.WIDTH(ufx_pkg::BYTE_W), .DEPTH(RX_DEPTH)) u_rx_ram (
      .clock (clock),
      .en    (rx_ctl.push | rx_ctl.pop),
      .we    (rx_ctl.push),
      .addr  (rx_ctl.push ? rx_head : rx_tail),
      .wdata (req_data_byte),
      .rdata (rx_rdata)
   );

   ufx_ram #(.WIDTH(ufx_pkg::BYTE_W), .DEPTH(TX_DEPTH)) u_tx_ram (
      .clock (clock),
      .en    (tx_ctl.push | tx_ctl.pop),
      .we    (tx_ctl.push),
      .addr  (tx_ctl.push ? tx_head : tx_tail),
      .wdata (req_data_byte),
      .rdata (tx_rdata)
   );

   // ---------------------------------------------------------------------
   // Request decode and state update
   // ---------------------------------------------------------------------
   logic                        accept;
   ufx_pkg::flow_mode_type      flow_mode_ff, flow_mode_in;
   logic                        tx_enable_ff, tx_enable_in;
   logic [ufx_pkg::PORT_W-1:0]  active_port_ff, active_port_in;

   logic                        rd_take, rd_empty, refused, dropped;
   ufx_pkg::line_src_type       line_src;
   logic [ufx_pkg::BYTE_W-1:0]  flow_char;

   logic [CMP_W-1:0] rx_level_inc, rx_level_dec, high_ext, low_ext;

   assign busy   = 1'b0;
   assign accept = start & ~busy;

   // levels as they stand after one push or one pop
   assign rx_level_inc = CMP_W'(rx_level) + 1'b1;
   assign rx_level_dec = CMP_W'(rx_level) - 1'b1;
   assign high_ext     = CMP_W'(rx_high_mark_ff);
   assign low_ext      = CMP_W'(rx_low_mark_ff);

   always_comb begin
      rx_ctl         = '0;
      tx_ctl         = '0;
      flow_mode_in   = flow_mode_ff;
      tx_enable_in   = tx_enable_ff;
      active_port_in = active_port_ff;
      rd_take        = 1'b0;
      rd_empty       = 1'b0;
      refused        = 1'b0;
      dropped        = 1'b0;
      line_src       = ufx_pkg::LINE_NONE;
      flow_char      = xon_byte_ff;
      if (accept) begin
         unique case (ufx_pkg::req_code_type'(req_type))
            ufx_pkg::REQ_RX_BYTE: begin
               active_port_in = req_port;
               if (rx_flag.full) begin
                  dropped = 1'b1;
               end else begin
                  rx_ctl.push = 1'b1;
                  if (flow_enable_ff && flow_mode_ff == ufx_pkg::FLOW_XON_SENT &&
                      rx_level_inc >= high_ext) begin
                     flow_mode_in = ufx_pkg::FLOW_XOFF_PEND;
                     tx_enable_in = 1'b1;
                  end
               end
            end
            ufx_pkg::REQ_HOST_READ: begin
               if (rx_flag.empty) begin
                  rd_empty = 1'b1;
               end else begin
                  rx_ctl.pop = 1'b1;
                  rd_take    = 1'b1;
                  if (flow_enable_ff && flow_mode_ff == ufx_pkg::FLOW_XOFF_SENT &&
                      rx_level_dec < low_ext) begin
                     flow_mode_in = ufx_pkg::FLOW_XON_PEND;
                     tx_enable_in = 1'b1;
                  end
               end
            end
            ufx_pkg::REQ_HOST_WRITE: begin
               if (tx_flag.full) begin
                  refused = 1'b1;
               end else begin
                  tx_ctl.push  = 1'b1;
                  tx_enable_in = 1'b1;
               end
            end
            ufx_pkg::REQ_TX_READY: begin
               if (tx_enable_ff) begin
                  // a queued flow character goes ahead of buffered data
                  if (flow_enable_ff && flow_mode_ff == ufx_pkg::FLOW_XOFF_PEND) begin
                     line_src     = ufx_pkg::LINE_FLOW;
                     flow_char    = xoff_byte_ff;
                     flow_mode_in = ufx_pkg::FLOW_XOFF_SENT;
                  end else if (flow_enable_ff &&
                               flow_mode_ff == ufx_pkg::FLOW_XON_PEND) begin
                     line_src     = ufx_pkg::LINE_FLOW;
                     flow_char    = xon_byte_ff;
                     flow_mode_in = ufx_pkg::FLOW_XON_SENT;
                  end else if (!tx_flag.empty) begin
                     line_src   = ufx_pkg::LINE_BUF;
                     tx_ctl.pop = 1'b1;
                  end
                  // drained: empty already, or the last byte just left
                  if (tx_flag.empty || (tx_ctl.pop && tx_level == TX_PTR_W'(1))) begin
                     tx_enable_in = 1'b0;
                  end
               end
            end
            ufx_pkg::REQ_RX_FLUSH: begin
               rx_ctl.flush = 1'b1;
               flow_mode_in = ufx_pkg::FLOW_XON_SENT;
            end
            default: ;  // unused codes only report status
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         flow_mode_ff   <= ufx_pkg::FLOW_XON_SENT;
         tx_enable_ff   <= 1'b0;
         active_port_ff <= '0;
      end else begin
         flow_mode_ff   <= flow_mode_in;
         tx_enable_ff   <= tx_enable_in;
         active_port_ff <= active_port_in;
      end
   end

   // ---------------------------------------------------------------------
   // Result stage: flags registered alongside the RAM read
   // ---------------------------------------------------------------------
   logic                        rsp_strobe_ff;
   logic                        rd_take_ff, rd_empty_ff, refused_ff, dropped_ff;
   ufx_pkg::line_src_type       line_src_ff;
   logic [ufx_pkg::BYTE_W-1:0]  flow_char_ff;
   logic [CMP_W-1:0]            rx_level_ext, tx_level_ext;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
         rd_take_ff    <= 1'b0;
         rd_empty_ff   <= 1'b0;
         refused_ff    <= 1'b0;
         dropped_ff    <= 1'b0;
         line_src_ff   <= ufx_pkg::LINE_NONE;
      end else begin
         rsp_strobe_ff <= accept;
         rd_take_ff    <= rd_take;
         rd_empty_ff   <= rd_empty;
         refused_ff    <= refused;
         dropped_ff    <= dropped;
         line_src_ff   <= line_src;
      end
   end

   always_ff @(posedge clock) begin
      flow_char_ff <= flow_char;
   end

   always_comb begin
      case (line_src_ff)
         ufx_pkg::LINE_FLOW: rsp_line_byte = flow_char_ff;
         ufx_pkg::LINE_BUF:  rsp_line_byte = tx_rdata;
         default:            rsp_line_byte = '0;
      endcase
   end

   assign rx_level_ext = CMP_W'(rx_level);
   assign tx_level_ext = CMP_W'(tx_level);

   assign rsp_strobe        = rsp_strobe_ff;
   assign rsp_read_data     = rd_take_ff ? rx_rdata : '0;
   assign rsp_read_empty    = rd_empty_ff;
   assign rsp_line_valid    = (line_src_ff != ufx_pkg::LINE_NONE);
   assign rsp_write_refused = refused_ff;
   assign rsp_rx_dropped    = dropped_ff;
   assign rsp_tx_irq_on     = tx_enable_ff;
   assign rsp_tx_port       = active_port_ff;
   assign rsp_flow_state    = flow_mode_ff;
   assign rsp_rx_level      = rx_level_ext[ufx_pkg::RX_LEVEL_W-1:0];
   assign rsp_tx_level      = tx_level_ext[ufx_pkg::TX_LEVEL_W-1:0];

   // ---------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------
   // every accepted request yields its result in the next cycle
   `UFX_ASSERT_NEXT(a_rsp_follows_req, clock, reset, accept, rsp_strobe)
   // a dropped byte means the receive buffer is still full
   `UFX_ASSERT_NOW(a_drop_when_full, clock, reset, rsp_rx_dropped, rx_flag.full)
   // buffered transmit data always keeps the transmit enable on
   `UFX_ASSERT_NOW(a_tx_data_enabled, clock, reset, !tx_flag.empty, tx_enable_ff)

endmodule

[tb/sv/uart_fifo_xon_xoff_core_tb.sv]
// Testbench for the serial buffer core: queued request driver, result checker, XON/XOFF predictor.
`timescale 1ns / 1ps
module uart_fifo_xon_xoff_core_tb;

   localparam int REQ_TYPE_W  = ufx_pkg::REQ_TYPE_W;
   localparam int BYTE_W      = ufx_pkg::BYTE_W;
   localparam int PORT_W      = ufx_pkg::PORT_W;
   localparam int MARK_W      = ufx_pkg::MARK_W;
   localparam int RX_LEVEL_W  = ufx_pkg::RX_LEVEL_W;
   localparam int TX_LEVEL_W  = ufx_pkg::TX_LEVEL_W;
   localparam int CSR_INDEX_W = ufx_pkg::CSR_INDEX_W;
   localparam int CSR_DATA_W  = ufx_pkg::CSR_DATA_W;

   // ---------------------------------------------------------------------
   // Clock and reset. The clock inverts every half period (8 ns period).
   // Reset is synchronous, held at the start of the run, never again.
   // ---------------------------------------------------------------------
   logic clock = 1'b0;
   logic reset = 1'b1;

   always #4 clock = ~clock;

   // DUT inputs start at known values and are driven by NBA at posedge
   logic                   start         = 1'b0;
   logic [REQ_TYPE_W-1:0]  req_type      = '0;
   logic [BYTE_W-1:0]      req_data_byte = '0;
   logic [PORT_W-1:0]      req_port      = '0;
   logic                   csr_we        = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index     = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata     = '0;

   logic                  busy;
   logic                  rsp_strobe;
   logic [BYTE_W-1:0]     rsp_read_data;
   logic                  rsp_read_empty;
   logic [BYTE_W-1:0]     rsp_line_byte;
   logic                  rsp_line_valid;
   logic                  rsp_write_refused;
   logic                  rsp_rx_dropped;
   logic                  rsp_tx_irq_on;
   logic [PORT_W-1:0]     rsp_tx_port;
   logic [1:0]            rsp_flow_state;
   logic [RX_LEVEL_W-1:0] rsp_rx_level;
   logic [TX_LEVEL_W-1:0] rsp_tx_level;

   uart_fifo_xon_xoff_core dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_type          (req_type),
      .req_data_byte     (req_data_byte),
      .req_port          (req_port),
      .rsp_strobe        (rsp_strobe),
      .rsp_read_data     (rsp_read_data),
      .rsp_read_empty    (rsp_read_empty),
      .rsp_line_byte     (rsp_line_byte),
      .rsp_line_valid    (rsp_line_valid),
      .rsp_write_refused (rsp_write_refused),
      .rsp_rx_dropped    (rsp_rx_dropped),
      .rsp_tx_irq_on     (rsp_tx_irq_on),
      .rsp_tx_port       (rsp_tx_port),
      .rsp_flow_state    (rsp_flow_state),
      .rsp_rx_level      (rsp_rx_level),
      .rsp_tx_level      (rsp_tx_level),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   // ---------------------------------------------------------------------
   // Status of one request as the block reports it.
   // ---------------------------------------------------------------------
   typedef struct packed {
      logic [BYTE_W-1:0]     read_data;
      logic                  read_empty;
      logic [BYTE_W-1:0]     line_byte;
      logic                  line_valid;
      logic                  write_refused;
      logic                  rx_dropped;
      logic                  tx_irq_on;
      logic [PORT_W-1:0]     tx_port;
      logic [1:0]            flow_state;
      logic [RX_LEVEL_W-1:0] rx_level;
      logic [TX_LEVEL_W-1:0] tx_level;
   } status_type;

   // Plan of work for the driver: requests, register writes, pauses until
   // the block has answered everything, and changes of the sender gap rate.
   typedef enum logic [1:0] {
      STEP_REQ,
      STEP_CSR,
      STEP_QUIESCE,
      STEP_PACE
   } step_kind_type;

   typedef struct {
      step_kind_type          kind;
      logic [REQ_TYPE_W-1:0]  rtype;
      logic [BYTE_W-1:0]      data;
      logic [PORT_W-1:0]      port;
      ufx_pkg::csr_index_type idx;
      logic [CSR_DATA_W-1:0]  wdata;
      int unsigned            pct;
   } plan_step_type;

   plan_step_type event_plan_q[$];
   status_type    pending_status_q[$];
   int unsigned   planned_reqs   = 0;
   int unsigned   gap_pct        = 0;
   int unsigned   mismatch_count = 0;

   // ---------------------------------------------------------------------
   // Shadow of the core: registers, both rings, flow state machine.
   // Ring depths are powers of two, so pointers wrap at their width and
   // the fill level is a plain difference at that width.
   // ---------------------------------------------------------------------
   logic                  cf_flow_en = ufx_pkg::FLOW_ENABLE_RST;
   logic [MARK_W-1:0]     cf_hi      = ufx_pkg::RX_HIGH_MARK_RST;
   logic [MARK_W-1:0]     cf_lo      = ufx_pkg::RX_LOW_MARK_RST;
   logic [BYTE_W-1:0]     cf_xon     = ufx_pkg::XON_BYTE_RST;
   logic [BYTE_W-1:0]     cf_xoff    = ufx_pkg::XOFF_BYTE_RST;

   logic [BYTE_W-1:0]      m_rx_mem [ufx_pkg::RX_DEPTH_DEF];
   logic [BYTE_W-1:0]      m_tx_mem [ufx_pkg::TX_DEPTH_DEF];
   logic [RX_LEVEL_W-1:0]  m_rx_wr = '0;
   logic [RX_LEVEL_W-1:0]  m_rx_rd = '0;
   logic [TX_LEVEL_W-1:0]  m_tx_wr = '0;
   logic [TX_LEVEL_W-1:0]  m_tx_rd = '0;
   ufx_pkg::flow_mode_type m_flow  = ufx_pkg::FLOW_XON_SENT;
   logic                   m_tx_on = 1'b0;
   logic [PORT_W-1:0]      m_port  = '0;

   function automatic void load_csr_shadow(ufx_pkg::csr_index_type idx,
                                           logic [CSR_DATA_W-1:0] v);
      case (idx)
         ufx_pkg::CSR_FLOW_ENABLE:  cf_flow_en = v[0];
         ufx_pkg::CSR_RX_HIGH_MARK: cf_hi      = v[MARK_W-1:0];
         ufx_pkg::CSR_RX_LOW_MARK:  cf_lo      = v[MARK_W-1:0];
         ufx_pkg::CSR_XON_BYTE:     cf_xon     = v;
         ufx_pkg::CSR_XOFF_BYTE:    cf_xoff    = v;
         default: ;
      endcase
   endfunction

   // Advance the shadow by one request and return the status it reports.
   function automatic status_type serial_buffer_step(logic [REQ_TYPE_W-1:0] kind,
                                                     logic [BYTE_W-1:0] byte_in,
                                                     logic [PORT_W-1:0] port_in);
      status_type            s;
      logic [RX_LEVEL_W-1:0] rx_nxt;
      logic [TX_LEVEL_W-1:0] tx_nxt;
      logic [RX_LEVEL_W-1:0] rx_fill;
      s = '0;
      case (kind)
         ufx_pkg::REQ_RX_BYTE: begin
            // port follows the receiver even when the byte is dropped
            m_port = port_in;
            rx_nxt = m_rx_wr + 1'b1;
            if (rx_nxt == m_rx_rd) begin
               s.rx_dropped = 1'b1;
            end else begin
               m_rx_mem[m_rx_wr] = byte_in;
               m_rx_wr = rx_nxt;
               rx_fill = m_rx_wr - m_rx_rd;
               if (cf_flow_en && m_flow == ufx_pkg::FLOW_XON_SENT && rx_fill >= cf_hi) begin
                  m_flow  = ufx_pkg::FLOW_XOFF_PEND;
                  m_tx_on = 1'b1;
               end
            end
         end
         ufx_pkg::REQ_HOST_READ: begin
            if (m_rx_wr == m_rx_rd) begin
               s.read_empty = 1'b1;
            end else begin
               s.read_data = m_rx_mem[m_rx_rd];
               m_rx_rd = m_rx_rd + 1'b1;
               rx_fill = m_rx_wr - m_rx_rd;
               if (cf_flow_en && m_flow == ufx_pkg::FLOW_XOFF_SENT && rx_fill < cf_lo) begin
                  m_flow  = ufx_pkg::FLOW_XON_PEND;
                  m_tx_on = 1'b1;
               end
            end
         end
         ufx_pkg::REQ_HOST_WRITE: begin
            tx_nxt = m_tx_wr + 1'b1;
            if (tx_nxt == m_tx_rd) begin
               s.write_refused = 1'b1;
            end else begin
               m_tx_mem[m_tx_wr] = byte_in;
               m_tx_wr = tx_nxt;
               m_tx_on = 1'b1;
            end
         end
         ufx_pkg::REQ_TX_READY: begin
            // masked entirely while the transmit enable is off
            if (m_tx_on) begin
               if (cf_flow_en && m_flow == ufx_pkg::FLOW_XOFF_PEND) begin
                  s.line_byte  = cf_xoff;
                  s.line_valid = 1'b1;
                  m_flow = ufx_pkg::FLOW_XOFF_SENT;
               end else if (cf_flow_en && m_flow == ufx_pkg::FLOW_XON_PEND) begin
                  s.line_byte  = cf_xon;
                  s.line_valid = 1'b1;
                  m_flow = ufx_pkg::FLOW_XON_SENT;
               end else if (m_tx_wr != m_tx_rd) begin
                  s.line_byte  = m_tx_mem[m_tx_rd];
                  s.line_valid = 1'b1;
                  m_tx_rd = m_tx_rd + 1'b1;
               end
               if (m_tx_rd == m_tx_wr)
                  m_tx_on = 1'b0;
            end
         end
         ufx_pkg::REQ_RX_FLUSH: begin
            m_rx_rd = m_rx_wr;
            m_flow  = ufx_pkg::FLOW_XON_SENT;
         end
         default: ;
      endcase
      s.tx_irq_on  = m_tx_on;
      s.tx_port    = m_port;
      s.flow_state = m_flow;
      s.rx_level   = m_rx_wr - m_rx_rd;
      s.tx_level   = m_tx_wr - m_tx_rd;
      return s;
   endfunction

   // One line per mismatch.
   task automatic flag_mismatch(string what, int unsigned got, int unsigned want);
      mismatch_count++;
      $display("%0t: mismatch on %s: got %0d, want %0d", $realtime, what, got, want);
   endtask

   // ---------------------------------------------------------------------
   // Driver. At each edge: if the presented request was taken, predict it;
   // then pick the next plan step. Register writes and quiesce points wait
   // until every expected result has come back. start gets exactly one
   // NBA per edge so it can stay high across back-to-back requests.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      logic          launch;
      logic          wr_now;
      logic          settled;
      plan_step_type nxt;
      launch  = 1'b0;
      wr_now  = 1'b0;
      settled = 1'b0;
      if (reset) begin
         start  <= 1'b0;
         csr_we <= 1'b0;
      end else begin
         if (start && !busy)
            pending_status_q.push_back(serial_buffer_step(req_type, req_data_byte, req_port));
         if (start && busy) begin
            launch = 1'b1;   // not taken yet, keep it on the port
         end else begin
            while (!settled && event_plan_q.size() != 0) begin
               nxt = event_plan_q[0];
               case (nxt.kind)
                  STEP_PACE: begin
                     gap_pct = nxt.pct;
                     void'(event_plan_q.pop_front());
                  end
                  STEP_QUIESCE: begin
                     if (pending_status_q.size() == 0)
                        void'(event_plan_q.pop_front());
                     else
                        settled = 1'b1;
                  end
                  STEP_CSR: begin
                     if (pending_status_q.size() == 0) begin
                        wr_now = 1'b1;
                        csr_index <= nxt.idx;
                        csr_wdata <= nxt.wdata;
                        load_csr_shadow(nxt.idx, nxt.wdata);
                        void'(event_plan_q.pop_front());
                     end
                     settled = 1'b1;
                  end
                  default: begin
                     // random sender gap, drawn per cycle
                     if ($urandom_range(0, 99) >= gap_pct) begin
                        launch = 1'b1;
                        req_type      <= nxt.rtype;
                        req_data_byte <= nxt.data;
                        req_port      <= nxt.port;
                        void'(event_plan_q.pop_front());
                     end
                     settled = 1'b1;
                  end
               endcase
            end
         end
         start  <= launch;
         csr_we <= wr_now;
      end
   end

   // ---------------------------------------------------------------------
   // Monitor. A strobed result is taken at the edge ending its cycle and
   // compared field by field with the oldest prediction.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      status_type want;
      if (!reset && rsp_strobe) begin
         if (pending_status_q.size() == 0) begin
            flag_mismatch("result with no request outstanding", 1, 0);
         end else begin
            want = pending_status_q.pop_front();
            if (rsp_read_data !== want.read_data)
               flag_mismatch("read_data", 32'(rsp_read_data), 32'(want.read_data));
            if (rsp_read_empty !== want.read_empty)
               flag_mismatch("read_empty", 32'(rsp_read_empty), 32'(want.read_empty));
            if (rsp_line_byte !== want.line_byte)
               flag_mismatch("line_byte", 32'(rsp_line_byte), 32'(want.line_byte));
            if (rsp_line_valid !== want.line_valid)
               flag_mismatch("line_valid", 32'(rsp_line_valid), 32'(want.line_valid));
            if (rsp_write_refused !== want.write_refused)
               flag_mismatch("write_refused", 32'(rsp_write_refused),
                             32'(want.write_refused));
            if (rsp_rx_dropped !== want.rx_dropped)
               flag_mismatch("rx_dropped", 32'(rsp_rx_dropped), 32'(want.rx_dropped));
            if (rsp_tx_irq_on !== want.tx_irq_on)
               flag_mismatch("tx_irq_on", 32'(rsp_tx_irq_on), 32'(want.tx_irq_on));
            if (rsp_tx_port !== want.tx_port)
               flag_mismatch("tx_port", 32'(rsp_tx_port), 32'(want.tx_port));
            if (rsp_flow_state !== want.flow_state)
               flag_mismatch("flow_state", 32'(rsp_flow_state), 32'(want.flow_state));
            if (rsp_rx_level !== want.rx_level)
               flag_mismatch("rx_level", 32'(rsp_rx_level), 32'(want.rx_level));
            if (rsp_tx_level !== want.tx_level)
               flag_mismatch("tx_level", 32'(rsp_tx_level), 32'(want.tx_level));
         end
      end
   end

   // ---------------------------------------------------------------------
   // Plan builders.
   // ---------------------------------------------------------------------
   task automatic add_req(logic [REQ_TYPE_W-1:0] t, logic [BYTE_W-1:0] d,
                          logic [PORT_W-1:0] p);
      plan_step_type e;
      e = '{kind: STEP_REQ, rtype: t, data: d, port: p, idx: ufx_pkg::CSR_FLOW_ENABLE,
            wdata: '0, pct: 0};
      event_plan_q.push_back(e);
      planned_reqs++;
   endtask

   task automatic add_csr(ufx_pkg::csr_index_type idx, logic [CSR_DATA_W-1:0] v);
      plan_step_type e;
      e = '{kind: STEP_CSR, rtype: '0, data: '0, port: '0, idx: idx, wdata: v, pct: 0};
      event_plan_q.push_back(e);
   endtask

   task automatic add_quiesce();
      plan_step_type e;
      e = '{kind: STEP_QUIESCE, rtype: '0, data: '0, port: '0,
            idx: ufx_pkg::CSR_FLOW_ENABLE, wdata: '0, pct: 0};
      event_plan_q.push_back(e);
   endtask

   task automatic add_pace(int unsigned pct);
      plan_step_type e;
      e = '{kind: STEP_PACE, rtype: '0, data: '0, port: '0,
            idx: ufx_pkg::CSR_FLOW_ENABLE, wdata: '0, pct: pct};
      event_plan_q.push_back(e);
   endtask

   // Bursts of one request kind fill and drain the rings far enough to hit
   // the marks, drops and refusals; the rest is mixed traffic and noise.
   task automatic add_episode();
      int unsigned pick;
      int unsigned len;
      pick = $urandom_range(0, 11);
      len  = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 140) : $urandom_range(1, 24);
      case (pick)
         0, 1, 2: repeat (len)
            add_req(ufx_pkg::REQ_RX_BYTE, BYTE_W'($urandom_range(0, 255)),
                    PORT_W'($urandom_range(0, 3)));
         3, 4: repeat (len)
            add_req(ufx_pkg::REQ_HOST_READ, BYTE_W'($urandom_range(0, 255)),
                    PORT_W'($urandom_range(0, 3)));
         5: repeat (len)
            add_req(ufx_pkg::REQ_HOST_WRITE, BYTE_W'($urandom_range(0, 255)),
                    PORT_W'($urandom_range(0, 3)));
         6, 7: repeat (len)
            add_req(ufx_pkg::REQ_TX_READY, BYTE_W'($urandom_range(0, 255)),
                    PORT_W'($urandom_range(0, 3)));
         8, 9: repeat (len)
            add_req(REQ_TYPE_W'($urandom_range(0, 3)), BYTE_W'($urandom_range(0, 255)),
                    PORT_W'($urandom_range(0, 3)));
         10: add_req(ufx_pkg::REQ_RX_FLUSH, BYTE_W'($urandom_range(0, 255)),
                     PORT_W'($urandom_range(0, 3)));
         default: add_req(REQ_TYPE_W'($urandom_range(5, 7)), BYTE_W'($urandom_range(0, 255)),
                          PORT_W'($urandom_range(0, 3)));
      endcase
   endtask

   // One random phase: settle, rewrite every register (unused upper bits
   // randomized), set the sender gap rate, then two halves of traffic with
   // a wait for all outstanding results between them.
   task automatic add_phase(int unsigned pct, logic fen, logic [MARK_W-1:0] hi,
                            logic [MARK_W-1:0] lo, logic [BYTE_W-1:0] xon,
                            logic [BYTE_W-1:0] xoff);
      logic [CSR_DATA_W-1:0] w;
      int unsigned           goal;
      add_quiesce();
      w = CSR_DATA_W'($urandom);
      w[0] = fen;
      add_csr(ufx_pkg::CSR_FLOW_ENABLE, w);
      add_csr(ufx_pkg::CSR_RX_HIGH_MARK, {1'($urandom_range(0, 1)), hi});
      add_csr(ufx_pkg::CSR_RX_LOW_MARK, {1'($urandom_range(0, 1)), lo});
      add_csr(ufx_pkg::CSR_XON_BYTE, xon);
      add_csr(ufx_pkg::CSR_XOFF_BYTE, xoff);
      add_pace(pct);
      goal = planned_reqs + 125;
      while (planned_reqs < goal)
         add_episode();
      add_quiesce();
      goal = planned_reqs + 125;
      while (planned_reqs < goal)
         add_episode();
   endtask

   // ---------------------------------------------------------------------
   // Stimulus and end of run.
   // ---------------------------------------------------------------------
   initial begin
      add_pace(0);
      add_csr(ufx_pkg::CSR_FLOW_ENABLE, 8'h01);
      add_csr(ufx_pkg::CSR_RX_HIGH_MARK, 8'h02);
      add_csr(ufx_pkg::CSR_RX_LOW_MARK, 8'h01);
      add_csr(ufx_pkg::CSR_XON_BYTE, 8'h11);
      add_csr(ufx_pkg::CSR_XOFF_BYTE, 8'h13);
      // empty read, transmit event while disabled
      add_req(ufx_pkg::REQ_HOST_READ, 8'h00, 2'd0);
      add_req(ufx_pkg::REQ_TX_READY, 8'hFF, 2'd3);
      // extreme bytes and ports; second byte reaches the high mark -> XOFF
      add_req(ufx_pkg::REQ_RX_BYTE, 8'h00, 2'd3);
      add_req(ufx_pkg::REQ_RX_BYTE, 8'hFF, 2'd1);
      add_req(ufx_pkg::REQ_TX_READY, 8'h00, 2'd0);
      add_req(ufx_pkg::REQ_RX_BYTE, 8'hA5, 2'd2);
      // drain below the low mark -> XON queued
      repeat (3) add_req(ufx_pkg::REQ_HOST_READ, 8'h00, 2'd0);
      add_req(ufx_pkg::REQ_HOST_WRITE, 8'h00, 2'd0);
      add_req(ufx_pkg::REQ_HOST_WRITE, 8'hFF, 2'd0);
      // flow character goes ahead of buffered bytes, then enable drops
      repeat (3) add_req(ufx_pkg::REQ_TX_READY, 8'h00, 2'd0);
      // unused request codes
      add_req(3'd5, 8'h5A, 2'd1);
      add_req(3'd6, 8'hC3, 2'd2);
      add_req(3'd7, 8'hFF, 2'd3);
      // flush with XOFF pending
      add_req(ufx_pkg::REQ_RX_BYTE, 8'h5A, 2'd0);
      add_req(ufx_pkg::REQ_RX_BYTE, 8'h3C, 2'd2);
      add_req(ufx_pkg::REQ_RX_FLUSH, 8'h00, 2'd0);
      // XOFF queued, then flow off: transmit event on empty ring sends
      // nothing and clears the enable
      add_req(ufx_pkg::REQ_RX_BYTE, 8'h81, 2'd1);
      add_req(ufx_pkg::REQ_RX_BYTE, 8'h7E, 2'd2);
      add_quiesce();
      add_csr(ufx_pkg::CSR_FLOW_ENABLE, 8'h00);
      add_req(ufx_pkg::REQ_TX_READY, 8'h00, 2'd0);
      // both marks zero: every byte qualifies for XOFF, XON never queued
      add_csr(ufx_pkg::CSR_FLOW_ENABLE, 8'hFF);
      add_csr(ufx_pkg::CSR_RX_HIGH_MARK, 8'h00);
      add_csr(ufx_pkg::CSR_RX_LOW_MARK, 8'h80);
      add_req(ufx_pkg::REQ_RX_FLUSH, 8'h00, 2'd0);
      add_req(ufx_pkg::REQ_RX_BYTE, 8'h42, 2'd0);
      add_req(ufx_pkg::REQ_TX_READY, 8'h00, 2'd0);
      add_req(ufx_pkg::REQ_HOST_READ, 8'h00, 2'd0);

      // random phases: extreme marks, sparse sender, flow off, busy sender
      add_phase(0, 1'b1, 7'd127, 7'd127, 8'h00, 8'hFF);
      add_phase(61, 1'b1, MARK_W'($urandom_range(1, 24)), MARK_W'($urandom_range(1, 24)),
                BYTE_W'($urandom_range(0, 255)), BYTE_W'($urandom_range(0, 255)));
      add_phase(0, 1'b0, 7'd96, 7'd64, BYTE_W'($urandom_range(0, 255)),
                BYTE_W'($urandom_range(0, 255)));
      add_phase(18, 1'b1, 7'd1, MARK_W'($urandom_range(1, 8)), 8'hFF, 8'h00);

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      while (event_plan_q.size() != 0 || start)
         @(posedge clock);
      // the last request may still be going onto the port
      repeat (2) @(posedge clock);
      // results come back in the cycle after acceptance; allow a little slack before calling it lost
      repeat (20) begin
         if (pending_status_q.size() == 0)
            break;
         @(posedge clock);
      end
      if (pending_status_q.size() != 0)
         flag_mismatch("results never returned", 0, pending_status_q.size());
      repeat (4) @(posedge clock);

      if (mismatch_count == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

   // hard stop well beyond the slowest legal run
   initial begin
      #(2_000_000);
      $display("TB_ERROR");
      $finish;
   end

endmodule
